// File: hw/rtl/fbpa_pkg.sv
// fbpa_pkg: shared types, codes and constants of the fixed block pool allocator
// no dependencies; used by the interfaces, the divider, the bitmap and the top level
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int OFS_W       = 28;  // byte offset fields
  localparam int BB_W        = 29;  // block_bytes register
  localparam int BIU_W       = 11;  // blocks_in_use register
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 29;
  localparam int WORD_BITS   = 32;  // bitmap row width
  localparam int WORD_LOG2   = 5;
  localparam int DIV_CNT_W   = $clog2(OFS_W + 1);

  localparam logic [BB_W-1:0]  RESET_BLOCK_BYTES   = BB_W'(262144);
  localparam logic [BIU_W-1:0] RESET_BLOCKS_IN_USE = BIU_W'(1024);

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_BYTES   = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_SCAN,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_DIV_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             start;
    logic [OFS_W-1:0] dividend;
    logic [BB_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OFS_W-1:0] quot;
    logic [BB_W-1:0]  rem;
  } div_stat_t;

endpackage

// File: hw/rtl/fbpa_ifs.sv
// fbpa_ifs: valid/ready channel interfaces for request and response words
// depends on fbpa_pkg for field widths
`timescale 1ns / 1ps

interface fbpa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [fbpa_pkg::OFS_W-1:0] free_offset;

  modport source (output valid, action, free_offset, input ready);
  modport sink   (input valid, action, free_offset, output ready);
endinterface

interface fbpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [fbpa_pkg::OFS_W-1:0] granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

// File: hw/rtl/fbpa_div.sv
// fbpa_div: restoring divider, one quotient bit per cycle
// depends on fbpa_pkg (div_req_t, div_stat_t, widths)
`timescale 1ns / 1ps

module fbpa_div (
  input  logic                clk,
  input  logic                rst,
  input  fbpa_pkg::div_req_t  req,
  output fbpa_pkg::div_stat_t stat
);

  logic [fbpa_pkg::OFS_W-1:0]     quot;
  logic [fbpa_pkg::BB_W-1:0]      rem;
  logic [fbpa_pkg::BB_W-1:0]      dvs;
  logic [fbpa_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [fbpa_pkg::BB_W:0]        trial;
  logic                           take;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quot[fbpa_pkg::OFS_W-1]};
    take  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= fbpa_pkg::DIV_CNT_W'(fbpa_pkg::OFS_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == fbpa_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= req.dividend;
      dvs  <= req.divisor;
    end else if (busy) begin
      if (take) begin
        rem <= fbpa_pkg::BB_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[fbpa_pkg::BB_W-1:0];
      end
      quot <= {quot[fbpa_pkg::OFS_W-2:0], take};
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;
  assign stat.rem  = rem;

endmodule

// File: hw/rtl/fbpa_bitmap.sv
// fbpa_bitmap: used-bit memory, 32 blocks to a row, with clearing sweep after reset
// depends on fbpa_pkg (row width)
`timescale 1ns / 1ps

module fbpa_bitmap #(
  parameter int MAX_BLOCKS = 1024,
  localparam int NUM_WORDS =
    (MAX_BLOCKS + fbpa_pkg::WORD_BITS - 1) / fbpa_pkg::WORD_BITS,
  localparam int WA_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [WA_W-1:0]                rd_addr,
  output logic [fbpa_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [WA_W-1:0]                wr_addr,
  input  logic [fbpa_pkg::WORD_BITS-1:0] wr_data,
  output logic                           clr_busy
);

  logic [fbpa_pkg::WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WA_W-1:0]                clr_cnt;
  logic                           we;
  logic [WA_W-1:0]                wa;
  logic [fbpa_pkg::WORD_BITS-1:0] wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      if (clr_cnt == WA_W'(NUM_WORDS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    if (clr_busy) begin
      we = 1'b1;
      wa = clr_cnt;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/fixed_block_pool_allocator_top.sv
// allocate: when the block after the last grant is free, the request runs NEXT_RD, NEXT_CHK, MUL, CHECK, RESP;
//   otherwise the bitmap is scanned one 32-bit row per cycle from its single read port
//   over the rows that hold the usable blocks
// free: the offset goes through the divider, which yields one quotient bit per cycle
// reset: synchronous; a clearing pass over all ceil(MAX_BLOCKS/32) rows (32 by default) runs
//   after reset with req.ready low; config writes are taken during it
`timescale 1ns / 1ps

module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS     = 1024,
  parameter int POOL_ADDR_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  fbpa_req_if.sink                        req,
  fbpa_rsp_if.source                      rsp
);

  localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CAP_CW    = (CNT_W > fbpa_pkg::BIU_W) ? CNT_W : fbpa_pkg::BIU_W;
  localparam int NUM_WORDS =
    (MAX_BLOCKS + fbpa_pkg::WORD_BITS - 1) / fbpa_pkg::WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WC_W      = $clog2(NUM_WORDS + 1);
  localparam int IW2       = IDX_W + fbpa_pkg::WORD_LOG2;
  localparam int BASE_W    = WA_W + fbpa_pkg::WORD_LOG2;
  localparam int LIM_CW    = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;
  localparam int LIM_W     = fbpa_pkg::WORD_LOG2 + 1;
  localparam int PROD_W    = IDX_W + fbpa_pkg::BB_W;
  localparam int CMP_W     =
    ((PROD_W > POOL_ADDR_BITS) ? PROD_W : POOL_ADDR_BITS) + 1;
  localparam logic [CMP_W-1:0] POOL_LIMIT = {{(CMP_W-1){1'b0}}, 1'b1} << POOL_ADDR_BITS;

  // configuration registers
  logic [fbpa_pkg::BB_W-1:0]  block_bytes;
  logic [fbpa_pkg::BIU_W-1:0] blocks_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= fbpa_pkg::RESET_BLOCK_BYTES;
      blocks_in_use <= fbpa_pkg::RESET_BLOCKS_IN_USE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbpa_pkg::REG_BLOCK_BYTES:   block_bytes   <= cfg_data;
        fbpa_pkg::REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[fbpa_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_pkg::state_t state;
  fbpa_pkg::state_t state_next;

  // item and sequencer registers
  logic                           is_free;
  logic [fbpa_pkg::OFS_W-1:0]     ofs;
  logic                           last_valid;
  logic [IDX_W-1:0]               last_idx;
  logic [IDX_W-1:0]               pick;
  logic                           try_next;
  logic [fbpa_pkg::WORD_BITS-1:0] cur_word;
  logic [WC_W-1:0]                issue_w;
  logic                           pend;
  logic [WA_W-1:0]                pend_w;
  logic [PROD_W-1:0]              prod;
  fbpa_pkg::status_t              res_status;
  logic [fbpa_pkg::OFS_W-1:0]     res_offset;
  logic                           rsp_valid;
  fbpa_pkg::status_t              rsp_status;
  logic [fbpa_pkg::OFS_W-1:0]     rsp_offset;

  // derived values
  logic [fbpa_pkg::BB_W-1:0]      b_eff;
  logic [CNT_W-1:0]               cap;
  logic [WC_W-1:0]                nwords;
  logic [CNT_W-1:0]               next_cnt;
  logic                           next_ok;
  logic [IDX_W-1:0]               next_idx;
  logic [WA_W-1:0]                next_addr;
  logic [fbpa_pkg::WORD_LOG2-1:0] next_bit;
  logic                           next_free;
  logic [WA_W-1:0]                pick_addr;
  logic [fbpa_pkg::WORD_LOG2-1:0] pick_bit;
  logic [fbpa_pkg::WORD_BITS-1:0] pick_mask;
  logic [fbpa_pkg::WORD_BITS-1:0] avail;
  logic [fbpa_pkg::WORD_LOG2-1:0] scan_enc;
  logic [LIM_W-1:0]               scan_lim;
  logic [IDX_W-1:0]               scan_pick;
  logic                           scan_found;
  logic                           scan_done;
  logic                           fit_ok;
  logic                           div_bad;
  logic                           rsp_load;
  logic                           req_fire;

  // bitmap and divider hookup
  logic                           bm_rd_en;
  logic [WA_W-1:0]                bm_rd_addr;
  logic [fbpa_pkg::WORD_BITS-1:0] bm_rd_data;
  logic                           bm_wr_en;
  logic [fbpa_pkg::WORD_BITS-1:0] bm_wr_data;
  logic                           clr_busy;
  logic                           req_ready;
  fbpa_pkg::div_req_t             div_req;
  fbpa_pkg::div_stat_t            div_stat;

  fbpa_bitmap #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_bitmap (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (bm_rd_en),
    .rd_addr  (bm_rd_addr),
    .rd_data  (bm_rd_data),
    .wr_en    (bm_wr_en),
    .wr_addr  (pick_addr),
    .wr_data  (bm_wr_data),
    .clr_busy (clr_busy)
  );

  fbpa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  always_comb begin
    logic [IW2-1:0]    next_wide;
    logic [IW2-1:0]    pick_wide;
    logic [CAP_CW-1:0] biu_ext;
    logic [CNT_W:0]    nw_sum;
    b_eff     = (block_bytes == '0) ? fbpa_pkg::BB_W'(1) : block_bytes;
    biu_ext   = CAP_CW'(blocks_in_use);
    cap       = (biu_ext > CAP_CW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(biu_ext);
    nw_sum    = (CNT_W + 1)'(cap) + (CNT_W + 1)'(fbpa_pkg::WORD_BITS - 1);
    nwords    = WC_W'(nw_sum >> fbpa_pkg::WORD_LOG2);
    next_cnt  = last_valid ? CNT_W'(last_idx) + CNT_W'(1) : '0;
    next_ok   = (next_cnt < cap);
    next_idx  = IDX_W'(next_cnt);
    next_wide = IW2'(next_idx);
    next_addr = WA_W'(next_wide >> fbpa_pkg::WORD_LOG2);
    next_bit  = next_wide[fbpa_pkg::WORD_LOG2-1:0];
    next_free = !bm_rd_data[next_bit];
    pick_wide = IW2'(pick);
    pick_addr = WA_W'(pick_wide >> fbpa_pkg::WORD_LOG2);
    pick_bit  = pick_wide[fbpa_pkg::WORD_LOG2-1:0];
    pick_mask = fbpa_pkg::WORD_BITS'(1) << pick_bit;
    fit_ok    = (CMP_W'(prod) + CMP_W'(b_eff)) <= POOL_LIMIT;
    div_bad   = (div_stat.rem != '0) || (div_stat.quot >= fbpa_pkg::OFS_W'(cap));
  end

  // free bits of the row that came back, blocks past the usable count read as used
  always_comb begin
    logic [LIM_CW-1:0] base;
    logic [LIM_CW-1:0] diff;
    base     = LIM_CW'({pend_w, {fbpa_pkg::WORD_LOG2{1'b0}}});
    diff     = LIM_CW'(cap) - base;
    scan_lim = (diff >= LIM_CW'(fbpa_pkg::WORD_BITS)) ?
               LIM_W'(fbpa_pkg::WORD_BITS) : LIM_W'(diff);
    for (int j = 0; j < fbpa_pkg::WORD_BITS; j++) begin
      avail[j] = !bm_rd_data[j] && (LIM_W'(j) < scan_lim);
    end
    scan_enc = '0;
    for (int j = fbpa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        scan_enc = fbpa_pkg::WORD_LOG2'(j);
      end
    end
    scan_pick  = IDX_W'({pend_w, scan_enc});
    scan_found = pend && (avail != '0);
    scan_done  = !pend && (issue_w >= nwords);
  end

  assign rsp_load = !rsp_valid || rsp.ready;
  assign req_fire = req.valid && req_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbpa_pkg::S_IDLE: begin
        if (req_fire) begin
          state_next = (req.action == fbpa_pkg::ACT_FREE) ? fbpa_pkg::S_DIV
                                                          : fbpa_pkg::S_NEXT_RD;
        end
      end
      fbpa_pkg::S_NEXT_RD: begin
        state_next = next_ok ? fbpa_pkg::S_NEXT_CHK : fbpa_pkg::S_SCAN;
      end
      fbpa_pkg::S_NEXT_CHK: begin
        state_next = next_free ? fbpa_pkg::S_MUL : fbpa_pkg::S_SCAN;
      end
      fbpa_pkg::S_SCAN: begin
        if (scan_found) begin
          state_next = fbpa_pkg::S_MUL;
        end else if (scan_done) begin
          state_next = fbpa_pkg::S_RESP;
        end
      end
      fbpa_pkg::S_MUL: begin
        state_next = fbpa_pkg::S_CHECK;
      end
      fbpa_pkg::S_CHECK: begin
        if (!is_free && !fit_ok && try_next) begin
          state_next = fbpa_pkg::S_SCAN;
        end else begin
          state_next = fbpa_pkg::S_RESP;
        end
      end
      fbpa_pkg::S_DIV: begin
        state_next = fbpa_pkg::S_DIV_WAIT;
      end
      fbpa_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = div_bad ? fbpa_pkg::S_RESP : fbpa_pkg::S_MUL;
        end
      end
      fbpa_pkg::S_RESP: begin
        if (rsp_load) begin
          state_next = fbpa_pkg::S_IDLE;
        end
      end
      default: state_next = fbpa_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready        = 1'b0;
    bm_rd_en         = 1'b0;
    bm_rd_addr       = pick_addr;
    bm_wr_en         = 1'b0;
    bm_wr_data       = is_free ? (bm_rd_data & ~pick_mask) : (cur_word | pick_mask);
    div_req.start    = 1'b0;
    div_req.dividend = ofs;
    div_req.divisor  = b_eff;
    unique case (state)
      fbpa_pkg::S_IDLE: begin
        req_ready = !clr_busy;
      end
      fbpa_pkg::S_NEXT_RD: begin
        bm_rd_en   = next_ok;
        bm_rd_addr = next_addr;
      end
      fbpa_pkg::S_SCAN: begin
        bm_rd_en   = (issue_w < nwords);
        bm_rd_addr = WA_W'(issue_w);
      end
      fbpa_pkg::S_MUL: begin
        bm_rd_en = is_free;
      end
      fbpa_pkg::S_CHECK: begin
        // free needs the bit set, allocate already knows it was clear
        bm_wr_en = fit_ok && (!is_free || bm_rd_data[pick_bit]);
      end
      fbpa_pkg::S_DIV: begin
        div_req.start = 1'b1;
      end
      fbpa_pkg::S_NEXT_CHK, fbpa_pkg::S_DIV_WAIT, fbpa_pkg::S_RESP: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fbpa_pkg::S_IDLE;
      last_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fbpa_pkg::S_CHECK && !is_free && fit_ok) begin
        last_valid <= 1'b1;
      end
      if (state == fbpa_pkg::S_RESP && rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      fbpa_pkg::S_IDLE: begin
        if (req_fire) begin
          is_free <= (req.action == fbpa_pkg::ACT_FREE);
          ofs     <= req.free_offset;
        end
      end
      fbpa_pkg::S_NEXT_RD: begin
        pick     <= next_idx;
        try_next <= 1'b0;
        issue_w  <= '0;
        pend     <= 1'b0;
      end
      fbpa_pkg::S_NEXT_CHK: begin
        if (next_free) begin
          cur_word <= bm_rd_data;
          try_next <= 1'b1;
        end
      end
      fbpa_pkg::S_SCAN: begin
        // read issue and row check overlap, one row per cycle
        pend   <= bm_rd_en;
        pend_w <= bm_rd_addr;
        if (bm_rd_en) begin
          issue_w <= issue_w + 1'b1;
        end
        if (scan_found) begin
          pick     <= scan_pick;
          cur_word <= bm_rd_data;
        end else if (scan_done) begin
          res_status <= fbpa_pkg::ST_FULL;
          res_offset <= '0;
        end
      end
      fbpa_pkg::S_MUL: begin
        prod <= PROD_W'(pick) * PROD_W'(b_eff);
      end
      fbpa_pkg::S_CHECK: begin
        res_offset <= '0;
        if (is_free) begin
          res_status <= bm_wr_en ? fbpa_pkg::ST_OK : fbpa_pkg::ST_BAD;
        end else if (fit_ok) begin
          res_status <= fbpa_pkg::ST_OK;
          res_offset <= prod[fbpa_pkg::OFS_W-1:0];
          last_idx   <= pick;
        end else if (try_next) begin
          try_next <= 1'b0;
          issue_w  <= '0;
          pend     <= 1'b0;
        end else begin
          res_status <= fbpa_pkg::ST_FULL;
        end
      end
      fbpa_pkg::S_DIV_WAIT: begin
        pick <= IDX_W'(div_stat.quot);
        if (div_stat.done && div_bad) begin
          res_status <= fbpa_pkg::ST_BAD;
          res_offset <= '0;
        end
      end
      fbpa_pkg::S_RESP: begin
        if (rsp_load) begin
          rsp_status <= res_status;
          rsp_offset <= res_offset;
        end
      end
      default: ;
    endcase
  end

  assign req.ready          = req_ready;
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.granted_offset = rsp_offset;

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != fbpa_pkg::ST_OK) |-> rsp.granted_offset == '0)
    else $error("failed request carries a nonzero offset");

  a_last_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(last_valid))
    else $error("last grant lost outside reset");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    bm_wr_en |-> !clr_busy)
    else $error("bitmap write during clearing pass");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == fbpa_pkg::S_DIV_WAIT)
    else $error("divider finished with no free in progress");

  a_free_keeps_last: assert property (@(posedge clk) disable iff (rst)
    (state == fbpa_pkg::S_CHECK) && is_free |=> $stable(last_idx) && $stable(last_valid))
    else $error("free changed the last grant");

endmodule
